// ----- hdl/stbs_pkg.sv -----
package stbs_pkg;

  localparam int unsigned CountWidth = 11;
  localparam int unsigned IndexWidth = 10;
  localparam int unsigned DataWidth  = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic write_en;  // store entry_value at entry_index
    logic load;      // capture key, reset bounds
    logic probe;     // read entry at midpoint
    logic step;      // compare read data, narrow bounds
    logic finish;    // move result into output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // bounds crossed, nothing left to probe
    logic eq;        // probed entry equals key
    logic out_free;  // output register can take a result
  } ctl_sts_t;

endpackage

// ----- hdl/stbs_datapath.sv -----
module stbs_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  stbs_pkg::ctl_cmd_t                      cmd,
  output stbs_pkg::ctl_sts_t                      sts,
  input  logic                                    cfg_valid,
  input  logic [stbs_pkg::CountWidth-1:0]         element_count,
  input  logic [stbs_pkg::IndexWidth-1:0]         entry_index,
  input  logic signed [stbs_pkg::DataWidth-1:0]   entry_value,
  input  logic signed [stbs_pkg::DataWidth-1:0]   search_key,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    found,
  output logic [stbs_pkg::IndexWidth-1:0]         position
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [stbs_pkg::DataWidth-1:0]        mem [TABLE_DEPTH];
  logic [stbs_pkg::DataWidth-1:0]        rd_data;
  logic [stbs_pkg::CountWidth-1:0]       elem_count;
  logic signed [stbs_pkg::DataWidth-1:0] key;
  logic [CW-1:0]                         lo;
  logic [CW-1:0]                         hix;   // exclusive upper bound
  logic [AW-1:0]                         mid;
  logic                                  hit;

  logic [31:0]   cnt32;
  logic [31:0]   cnt_sat;
  logic [31:0]   widx32;
  logic          widx_ok;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_calc;
  logic          gt;

  assign cnt32    = 32'(elem_count);
  assign cnt_sat  = (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;
  assign widx32   = 32'(entry_index);
  assign widx_ok  = widx32 < 32'(TABLE_DEPTH);
  // floor((lo + hi) / 2) with hi = hix - 1
  assign mid_sum  = (CW+1)'(lo) + (CW+1)'(hix) - (CW+1)'(1);
  assign mid_calc = AW'(mid_sum >> 1);
  assign gt       = $signed(rd_data) > key;

  assign sts.empty    = lo >= hix;
  assign sts.eq       = $signed(rd_data) == key;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
    end else if (cfg_valid) begin
      elem_count <= element_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_en && widx_ok) begin
      mem[widx32[AW-1:0]] <= entry_value;
    end
    if (cmd.probe) begin
      rd_data <= mem[mid_calc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= search_key;
      lo  <= '0;
      hix <= cnt_sat[CW-1:0];
      hit <= 1'b0;
    end else if (cmd.probe) begin
      mid <= mid_calc;
    end else if (cmd.step) begin
      if (sts.eq) begin
        hit <= 1'b1;
      end else if (gt) begin
        hix <= CW'(mid);
      end else begin
        lo <= CW'(mid) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found    <= hit;
      position <= hit ? stbs_pkg::IndexWidth'(32'(mid)) : '0;
    end
  end

  a_probe_in_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.probe |-> (lo < hix))
    else $error("probe issued with empty bounds");

  a_miss_position_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (position == '0))
    else $error("miss reported with nonzero position");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (!hit && lo == '0))
    else $error("search start did not reset bounds");

  a_bound_limit: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load) |-> (32'(hix) <= 32'(TABLE_DEPTH)))
    else $error("upper bound beyond table depth");

endmodule

// ----- hdl/stbs_ctrl.sv -----
module stbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  stbs_pkg::ctl_sts_t sts,
  output stbs_pkg::ctl_cmd_t cmd
);

  stbs_pkg::state_t state;
  stbs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      stbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == stbs_pkg::MODE_SEARCH) begin
            cmd.load   = 1'b1;
            state_next = stbs_pkg::ST_PROBE;
          end else begin
            cmd.write_en = 1'b1;
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (sts.empty) begin
          state_next = stbs_pkg::ST_FINISH;
        end else begin
          cmd.probe  = 1'b1;
          state_next = stbs_pkg::ST_COMPARE;
        end
      end
      stbs_pkg::ST_COMPARE: begin
        cmd.step   = 1'b1;
        state_next = sts.eq ? stbs_pkg::ST_FINISH : stbs_pkg::ST_PROBE;
      end
      stbs_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/sorted_table_binary_search.sv -----
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | mode, entry_index, entry_value, search_key
// cfg      | cfg_valid / cfg_ready| element_count
// out      | out_valid / out_ready| found, position
//
// a write item is stored straight from idle; a search item starts, then
// alternates probe and compare steps, then does a last bounds check and the
// result handover; a hit skips the last bounds check. each probe is a
// registered table read followed by a signed compare, which sets the pace.
// reset clears element_count to 0; table contents stay undefined until written.
// a finished result waits in the output register; a new item is taken as soon
// as the search has handed its result over, even while out_ready is low.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic [stbs_pkg::IndexWidth-1:0]       entry_index,
  input  logic signed [stbs_pkg::DataWidth-1:0] entry_value,
  input  logic signed [stbs_pkg::DataWidth-1:0] search_key,
  // configuration write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [stbs_pkg::CountWidth-1:0]       element_count,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  found,
  output logic [stbs_pkg::IndexWidth-1:0]       position
);

  stbs_pkg::ctl_cmd_t cmd;
  stbs_pkg::ctl_sts_t sts;

  // the count register is always free to take a write
  assign cfg_ready = 1'b1;

  // sequencer: table writes; search start, probe, compare, hand over the result
  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, search bounds, compare and output register
  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .element_count (element_count),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .search_key    (search_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .position      (position)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// keeps its own copy of the table and the count, replays each probe sequence
class lookup_board;
  localparam int Depth = 1024;

  typedef struct packed {
    logic                                found;
    logic [stbs_pkg::IndexWidth-1:0]     position;
  } answer_t;

  bit signed [stbs_pkg::DataWidth-1:0] entries [Depth];
  bit [stbs_pkg::CountWidth-1:0]       count_reg;
  answer_t                             awaited[$];
  int unsigned                         errors;
  int unsigned                         searches;
  int unsigned                         writes;
  int unsigned                         answers;
  int unsigned                         count_writes;

  task report_mismatch(string msg);
    errors++;
    $display("MISMATCH %s", msg);
  endtask

  task set_count(logic [stbs_pkg::CountWidth-1:0] value);
    count_reg = value;
    count_writes++;
  endtask

  function answer_t predict_lookup(logic signed [stbs_pkg::DataWidth-1:0] key);
    int          lo;
    int          hi;
    int          mid;
    int unsigned span;
    answer_t     a;
    span = (count_reg > Depth) ? Depth : count_reg;
    lo = 0;
    hi = int'(span) - 1;
    a = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (entries[mid] == key) begin
        a.found = 1'b1;
        a.position = mid[stbs_pkg::IndexWidth-1:0];
        break;
      end else if (entries[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return a;
  endfunction

  task note_item(logic m, logic [stbs_pkg::IndexWidth-1:0] idx,
                 logic signed [stbs_pkg::DataWidth-1:0] value,
                 logic signed [stbs_pkg::DataWidth-1:0] key);
    if (m == stbs_pkg::MODE_WRITE) begin
      entries[idx] = value;
      writes++;
    end else begin
      awaited.push_back(predict_lookup(key));
      searches++;
    end
  endtask

  task check_answer(logic f, logic [stbs_pkg::IndexWidth-1:0] p);
    answer_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("answer with no search pending: found=%0b position=%0d", f, p));
      return;
    end
    want = awaited.pop_front();
    answers++;
    if (f !== want.found)
      report_mismatch($sformatf("answer %0d: found=%0b, want %0b", answers, f, want.found));
    if (p !== want.position)
      report_mismatch($sformatf("answer %0d: position=%0d, want %0d",
                                answers, p, want.position));
  endtask

  task close_out();
    if (awaited.size() != 0)
      report_mismatch($sformatf("%0d searches never answered", awaited.size()));
  endtask
endclass

module testbench;

  localparam int unsigned STUCK_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 30;    // longer than one full search
  localparam int unsigned TOTAL_ITEMS   = 1750;
  localparam logic signed [stbs_pkg::DataWidth-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [stbs_pkg::DataWidth-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic                                  mode = stbs_pkg::MODE_WRITE;
  logic [stbs_pkg::IndexWidth-1:0]       entry_index = '0;
  logic signed [stbs_pkg::DataWidth-1:0] entry_value = '0;
  logic signed [stbs_pkg::DataWidth-1:0] search_key = '0;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [stbs_pkg::CountWidth-1:0]       element_count = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic                                  found;
  logic [stbs_pkg::IndexWidth-1:0]       position;

  lookup_board sb = new();

  // searches accepted but not yet answered, updated at the edge only
  int          outstanding = 0;
  int unsigned stuck_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned items_offered = 0;
  int unsigned cur_count = 0;
  // what the stimulus side last wrote, used to aim keys at real entries
  bit signed [stbs_pkg::DataWidth-1:0] shadow [1024];

  sorted_table_binary_search dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .search_key   (search_key),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .element_count(element_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .position     (position)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor: every handshake is seen here with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        sb.set_count(element_count);
      if (in_valid && in_ready)
        sb.note_item(mode, entry_index, entry_value, search_key);
      if (out_valid && out_ready)
        sb.check_answer(found, position);
      outstanding <= outstanding
                     + ((in_valid && in_ready && mode == stbs_pkg::MODE_SEARCH) ? 1 : 0)
                     - ((out_valid && out_ready) ? 1 : 0);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", stuck_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when the main flow asks for one
  always @(posedge clk) begin
    if (hold_asks != hold_taken) begin
      hold_taken <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic set_idling(idling_t how);
    case (how)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        gap_pct = 62;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct <= 62;
      end
      default: begin
        gap_pct = 20;
        stall_pct <= 20;
      end
    endcase
  endtask

  // one item on the input channel; valid stays up on return so the next
  // item can follow back to back
  task automatic offer_item(logic m, logic [stbs_pkg::IndexWidth-1:0] idx,
                            logic signed [stbs_pkg::DataWidth-1:0] value,
                            logic signed [stbs_pkg::DataWidth-1:0] key);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    entry_index <= idx;
    entry_value <= value;
    search_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_offered++;
    if (m == stbs_pkg::MODE_WRITE)
      shadow[idx] = value;
  endtask

  // sender stops and waits for every answer, then lets a write finish
  task automatic settle(int unsigned extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // count register only changes with the block idle
  task automatic write_count(logic [stbs_pkg::CountWidth-1:0] value);
    settle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    element_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_count = value;
  endtask

  // entries 0..n-1: ascending with duplicates, or scrambled
  task automatic fill_table(int unsigned n, bit in_order);
    longint acc;
    longint step_cap;
    longint step;
    longint v;
    if ($urandom_range(0, 7) == 0)
      acc = longint'(KEY_MIN);
    else
      acc = longint'(KEY_MIN) + longint'($urandom_range(0, 32'h7fff_ffff));
    for (int unsigned i = 0; i < n; i++) begin
      if (in_order) begin
        v = acc;
        if (i == n - 1 && $urandom_range(0, 7) == 0)
          v = longint'(KEY_MAX);
        step_cap = 2 * (longint'(KEY_MAX) - acc) / longint'(n);
        if ($urandom_range(0, 3) == 0)
          step = 0;  // duplicate run
        else
          step = longint'({$urandom, $urandom} % (step_cap + 1));
        acc = acc + step;
        if (acc > longint'(KEY_MAX))
          acc = longint'(KEY_MAX);
      end else begin
        v = longint'($signed($urandom));
      end
      offer_item(stbs_pkg::MODE_WRITE, i[stbs_pkg::IndexWidth-1:0],
                 v[stbs_pkg::DataWidth-1:0], $urandom);
    end
  endtask

  // keys: mostly present entries and their neighbors, some extremes, some noise
  function automatic logic signed [stbs_pkg::DataWidth-1:0] pick_key(int unsigned n);
    int unsigned                           r;
    logic signed [stbs_pkg::DataWidth-1:0] k;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 30) begin
      k = $urandom;
    end else if (r < 70) begin
      k = shadow[$urandom_range(0, n - 1)];
    end else if (r < 90) begin
      k = shadow[$urandom_range(0, n - 1)] + (($urandom_range(0, 1) == 1) ? 1 : -1);
    end else begin
      case ($urandom_range(0, 3))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = '0;
        default: k = -1;
      endcase
    end
    return k;
  endfunction

  // mostly searches, some stray writes that may break the ordering
  task automatic random_item(int unsigned n);
    logic [stbs_pkg::IndexWidth-1:0] idx;
    int unsigned                     pick;
    if ($urandom_range(0, 99) < 15) begin
      if (n != 0 && $urandom_range(0, 1) == 1)
        pick = $urandom_range(0, n - 1);
      else
        pick = $urandom;
      idx = pick[stbs_pkg::IndexWidth-1:0];
      offer_item(stbs_pkg::MODE_WRITE, idx, $urandom, $urandom);
    end else begin
      pick = $urandom;
      offer_item(stbs_pkg::MODE_SEARCH, pick[stbs_pkg::IndexWidth-1:0], $urandom,
                 pick_key(n));
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned reps;
    int unsigned r;
    bit          refill;
    logic signed [stbs_pkg::DataWidth-1:0] small_set [8];

    small_set = '{KEY_MIN, -5, -5, 0, 3, 3, 3, KEY_MAX};
    set_idling(IDLE_NONE);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero count straight out of reset
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, '0);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, KEY_MAX);
    // small sorted table with extremes and duplicate runs
    for (int i = 0; i < 8; i++)
      offer_item(stbs_pkg::MODE_WRITE, i[stbs_pkg::IndexWidth-1:0], small_set[i], $urandom);
    write_count(stbs_pkg::CountWidth'(8));
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, KEY_MIN);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, KEY_MAX);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, -5);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, 3);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, 0);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, 1);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, KEY_MIN + 1);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, KEY_MAX - 1);
    // single entry table
    write_count(stbs_pkg::CountWidth'(1));
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, KEY_MIN);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, 3);
    // zero count written explicitly
    write_count('0);
    offer_item(stbs_pkg::MODE_SEARCH, '0, $urandom, KEY_MIN);

    // whole table written once, so no count can reach an unwritten entry
    fill_table(1024, 1'b1);

    phase = 0;
    while (items_offered < TOTAL_ITEMS) begin
      refill = 1'b0;
      reps = $urandom_range(20, 50);
      if (phase == 0) begin
        n = 1024;
        reps = 60;
      end else if (phase == 1) begin
        n = 2047;  // beyond depth, saturates
        reps = 60;
      end else if (phase == 2) begin
        n = $urandom_range(1025, 2046);
        reps = 40;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          n = 0;
        end else if (r < 10) begin
          n = 1;
          refill = 1'b1;
        end else if (r < 14) begin
          n = $urandom_range(49, 1024);
        end else begin
          n = $urandom_range(2, 48);
          refill = 1'b1;
        end
      end
      set_idling((phase == 0) ? IDLE_NONE : idling_t'(phase % 4));
      if (refill) begin
        settle(SETTLE_CYCLES);
        fill_table(n, $urandom_range(0, 3) != 0);
      end
      write_count(n[stbs_pkg::CountWidth-1:0]);
      // first full-size phase: receiver holds off while the sender keeps going
      if (phase == 0)
        hold_asks <= hold_asks + 1;
      for (int unsigned k = 0; k < reps; k++)
        random_item((cur_count > 1024) ? 1024 : cur_count);
      phase++;
    end

    settle(40);
    sb.close_out();
    $display("ran %0d items in %0d phases: %0d searches, %0d writes, %0d count writes",
             items_offered, phase, sb.searches, sb.writes, sb.count_writes);
    $display("checked %0d answers, %0d mismatches", sb.answers, sb.errors);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
